[hdl/wpmt_pkg.sv]
// ----------------------------------------------------------------------------
// wpmt_pkg
// Shared types and constants of the walking pattern memory test sequencer.
// ----------------------------------------------------------------------------
package wpmt_pkg;

    // test phases, also shown on the result word
    typedef enum logic [2:0] {
        PH_DATA_ONES  = 3'd0,
        PH_DATA_ZEROS = 3'd1,
        PH_ADDR_ONES  = 3'd2,
        PH_ADDR_ZEROS = 3'd3,
        PH_DONE       = 3'd4
    } phase_t;

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // fixed field widths
    localparam int ADDR_W  = 19;
    localparam int ERR_W   = 16;
    localparam int EXP_W   = 5;
    localparam int PHASE_W = 3;
    localparam int CFG_W   = 5;

    // address test constants, size reset and error cap
    localparam logic [63:0]      START_PATTERN   = 64'h0003_0002_0001_0000;
    localparam logic [63:0]      PATTERN_STEP    = 64'h0004_0004_0004_0004;
    localparam logic [EXP_W-1:0] FIRST_EXP       = 5'd4;
    localparam int               LOW_BITS        = 4;
    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 5'd22;
    localparam logic [ERR_W-1:0] ERR_MAX         = 16'hffff;

endpackage

[hdl/wpmt_addr_gen.sv]
// ----------------------------------------------------------------------------
// wpmt_addr_gen
// Byte offset of the address tests and its conversion to a word index.
// ----------------------------------------------------------------------------
module wpmt_addr_gen #(
    parameter int DATA_WIDTH    = 64,
    parameter int MAX_SIZE_LOG2 = 22
) (
    input  logic                            zeros_walk,
    input  logic [wpmt_pkg::EXP_W-1:0]      exponent,
    input  logic [wpmt_pkg::EXP_W-1:0]      eff_size_log2,
    output logic [MAX_SIZE_LOG2-1:0]        word_index
);

    localparam int OFF_W   = MAX_SIZE_LOG2;
    localparam int BPW     = (DATA_WIDTH / 8 > 0) ? DATA_WIDTH / 8 : 1;
    localparam bit IS_POW2 = ((BPW & (BPW - 1)) == 0);
    localparam int BPW_LOG = $clog2(BPW);
    localparam int K       = OFF_W + 3;
    localparam int PROD_W  = OFF_W + K;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(BPW) - 64'd1) / 64'(BPW);
    localparam int LOW_BITS_SH = wpmt_pkg::LOW_BITS;

    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] size_mask;
    logic [OFF_W-1:0] byte_off;

    // one-hot offset and the region mask with the low line bits cleared
    always_comb
    begin
        offset    = {{(OFF_W-1){1'b0}}, 1'b1} << exponent;
        size_mask = ~({OFF_W{1'b1}} << eff_size_log2);
        size_mask = size_mask & ~OFF_W'((1 << LOW_BITS_SH) - 1);
        byte_off  = zeros_walk ? (~offset & size_mask) : offset;
    end

    // byte offset to word index
    generate
        if (IS_POW2)
        begin : g_shift
            assign word_index = byte_off >> BPW_LOG;
        end
        else
        begin : g_recip
            logic [PROD_W-1:0] prod;
            assign prod       = PROD_W'(byte_off) * PROD_W'(RECIP[K-1:0]);
            assign word_index = prod[K +: OFF_W];
        end
    endgenerate

endmodule

[hdl/wpmt_seq.sv]
// ----------------------------------------------------------------------------
// wpmt_seq
// Sequencer state and the single-step logic that checks the previous read,
// issues at most one memory command and advances the test.
// ----------------------------------------------------------------------------
module wpmt_seq #(
    parameter int DATA_WIDTH    = 64,
    parameter int LINE_WORDS    = 2,
    parameter int MAX_SIZE_LOG2 = 22
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic                            operation,
    input  logic [DATA_WIDTH-1:0]           read_data,
    input  logic [wpmt_pkg::CFG_W-1:0]      size_log2,
    output logic                            cmd_valid,
    output logic                            cmd_write,
    output logic [wpmt_pkg::ADDR_W-1:0]     cmd_word_address,
    output logic [DATA_WIDTH-1:0]           cmd_data,
    output logic                            mismatch,
    output logic [wpmt_pkg::PHASE_W-1:0]    test_phase,
    output logic [wpmt_pkg::ERR_W-1:0]      error_total,
    output logic                            finished
);

    localparam int SUB_RAW = $clog2(2 * LINE_WORDS + 1);
    localparam int SUB_W   = (SUB_RAW > 2) ? SUB_RAW : 2;
    localparam int TW_W    = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int BP_W    = $clog2(DATA_WIDTH);
    localparam int OFF_W   = MAX_SIZE_LOG2;
    localparam int ADDR_W  = wpmt_pkg::ADDR_W;
    localparam int EXP_W   = wpmt_pkg::EXP_W;
    localparam int SUM_W   = (OFF_W > ADDR_W) ? OFF_W : ADDR_W;

    localparam logic [SUB_W-1:0] SUB_L    = SUB_W'(LINE_WORDS);
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(2 * LINE_WORDS);
    localparam logic [BP_W-1:0]  BP_LAST  = BP_W'(DATA_WIDTH - 1);
    localparam logic [TW_W-1:0]  TW_LAST  = TW_W'(LINE_WORDS - 1);
    localparam logic [EXP_W-1:0] EXP_MAX  = EXP_W'(MAX_SIZE_LOG2);

    localparam logic [DATA_WIDTH-1:0] PAT_ONES  = wpmt_pkg::START_PATTERN[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] PAT_ZEROS = ~wpmt_pkg::START_PATTERN[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] PAT_STEP  = wpmt_pkg::PATTERN_STEP[DATA_WIDTH-1:0];

    typedef struct packed {
        wpmt_pkg::phase_t          phase;
        logic [TW_W-1:0]           tw;
        logic [BP_W-1:0]           bp;
        logic [SUB_W-1:0]          sub;
        logic [EXP_W-1:0]          exp;
        logic [DATA_WIDTH-1:0]     pat;
        logic                      pend;
        logic [DATA_WIDTH-1:0]     pend_exp;
        logic [wpmt_pkg::ERR_W-1:0] err;
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [EXP_W-1:0] eff_size;
    logic [OFF_W-1:0] word_index;
    logic             zeros_walk;
    seq_state_t       st_pre;

    // end address passes whose offset already reached the region size
    function automatic seq_state_t settle(input seq_state_t st_in,
                                          input logic [EXP_W-1:0] eff);
        seq_state_t s;
        s = st_in;
        for (int i = 0; i < 4; i++)
        begin
            if ((s.phase == wpmt_pkg::PH_ADDR_ONES || s.phase == wpmt_pkg::PH_ADDR_ZEROS)
                && s.exp >= eff)
            begin
                priority if (!s.sub[1])
                begin
                    s.sub = SUB_W'(2);
                    s.exp = wpmt_pkg::FIRST_EXP;
                    s.pat = (s.phase == wpmt_pkg::PH_ADDR_ONES) ? PAT_ONES : PAT_ZEROS;
                end
                else if (s.phase == wpmt_pkg::PH_ADDR_ONES)
                begin
                    s.phase = wpmt_pkg::PH_ADDR_ZEROS;
                    s.sub   = '0;
                    s.exp   = wpmt_pkg::FIRST_EXP;
                    s.pat   = PAT_ZEROS;
                end
                else
                begin
                    s.phase = wpmt_pkg::PH_DONE;
                end
            end
        end
        return s;
    endfunction

    // effective size, clamped to the largest supported region
    assign eff_size = (size_log2 > EXP_MAX) ? EXP_MAX : size_log2;

    // read check or restart, then settle before issuing
    always_comb
    begin
        seq_state_t s;
        s        = state_reg;
        mismatch = 1'b0;
        if (operation == wpmt_pkg::OP_START)
        begin
            s.err      = '0;
            s.pend     = 1'b0;
            s.pend_exp = '0;
            s.phase    = wpmt_pkg::PH_DATA_ONES;
            s.tw       = '0;
            s.bp       = '0;
            s.sub      = '0;
            s.exp      = wpmt_pkg::FIRST_EXP;
            s.pat      = '0;
        end
        else if (s.pend)
        begin
            if (read_data != s.pend_exp)
            begin
                mismatch = 1'b1;
                if (s.err != wpmt_pkg::ERR_MAX)
                begin
                    s.err = s.err + 1'b1;
                end
            end
            s.pend = 1'b0;
        end
        st_pre = settle(s, eff_size);
    end

    assign zeros_walk = (st_pre.phase == wpmt_pkg::PH_ADDR_ZEROS);

    wpmt_addr_gen #(
        .DATA_WIDTH    (DATA_WIDTH),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_addr_gen (
        .zeros_walk    (zeros_walk),
        .exponent      (st_pre.exp),
        .eff_size_log2 (eff_size),
        .word_index    (word_index)
    );

    // command issue and test advance
    always_comb
    begin
        seq_state_t            s;
        logic [DATA_WIDTH-1:0] one_hot;
        logic [DATA_WIDTH-1:0] fill;
        logic [DATA_WIDTH-1:0] pat_d;
        logic [SUB_W-1:0]      r;
        logic [SUM_W-1:0]      addr_sum;
        s                = st_pre;
        one_hot          = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << s.bp;
        fill             = (s.phase == wpmt_pkg::PH_DATA_ONES) ? '0 : '1;
        pat_d            = (s.phase == wpmt_pkg::PH_DATA_ONES) ? one_hot : ~one_hot;
        r                = s.sub - SUB_L - 1'b1;
        addr_sum         = SUM_W'(word_index) + SUM_W'(s.sub[0]);
        cmd_valid        = 1'b0;
        cmd_write        = 1'b0;
        cmd_word_address = '0;
        cmd_data         = '0;
        unique case (s.phase)
            wpmt_pkg::PH_DATA_ONES, wpmt_pkg::PH_DATA_ZEROS:
            begin
                cmd_valid = 1'b1;
                priority if (s.sub < SUB_L)
                begin
                    cmd_write        = 1'b1;
                    cmd_word_address = ADDR_W'(s.sub);
                    cmd_data         = fill;
                end
                else if (s.sub == SUB_L)
                begin
                    cmd_write        = 1'b1;
                    cmd_word_address = ADDR_W'(s.tw);
                    cmd_data         = pat_d;
                end
                else if (r + 1'b1 < SUB_L)
                begin
                    cmd_word_address = (r < SUB_W'(s.tw)) ? ADDR_W'(r) : ADDR_W'(r + 1'b1);
                    cmd_data         = fill;
                end
                else
                begin
                    cmd_word_address = ADDR_W'(s.tw);
                    cmd_data         = pat_d;
                end
                // step through the line, then bit positions, then ones to zeros, then target words
                if (s.sub == SUB_LAST)
                begin
                    s.sub = '0;
                    if (s.bp == BP_LAST)
                    begin
                        s.bp = '0;
                        if (s.phase == wpmt_pkg::PH_DATA_ONES)
                        begin
                            s.phase = wpmt_pkg::PH_DATA_ZEROS;
                        end
                        else if (s.tw == TW_LAST)
                        begin
                            s.phase = wpmt_pkg::PH_ADDR_ONES;
                            s.tw    = '0;
                            s.sub   = '0;
                            s.exp   = wpmt_pkg::FIRST_EXP;
                            s.pat   = PAT_ONES;
                        end
                        else
                        begin
                            s.phase = wpmt_pkg::PH_DATA_ONES;
                            s.tw    = s.tw + 1'b1;
                        end
                    end
                    else
                    begin
                        s.bp = s.bp + 1'b1;
                    end
                end
                else
                begin
                    s.sub = s.sub + 1'b1;
                end
            end
            wpmt_pkg::PH_ADDR_ONES, wpmt_pkg::PH_ADDR_ZEROS:
            begin
                cmd_valid        = 1'b1;
                cmd_write        = ~s.sub[1];
                cmd_word_address = addr_sum[ADDR_W-1:0];
                cmd_data         = s.pat;
                s.pat = (s.phase == wpmt_pkg::PH_ADDR_ONES) ? s.pat + PAT_STEP
                                                            : s.pat - PAT_STEP;
                // second word of the pair moves on to the next offset
                if (s.sub[0])
                begin
                    s.sub[0] = 1'b0;
                    s.exp    = s.exp + 1'b1;
                end
                else
                begin
                    s.sub[0] = 1'b1;
                end
            end
            default:
            begin
                cmd_valid = 1'b0;
            end
        endcase
        // a read leaves its expected value for the next item
        if (cmd_valid && !cmd_write)
        begin
            s.pend     = 1'b1;
            s.pend_exp = cmd_data;
        end
        state_next = settle(s, eff_size);
    end

    assign test_phase  = st_pre.phase;
    assign error_total = state_next.err;
    assign finished    = (state_next.phase == wpmt_pkg::PH_DONE) && !state_next.pend;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= wpmt_pkg::PH_DONE;
            state_reg.tw       <= '0;
            state_reg.bp       <= '0;
            state_reg.sub      <= '0;
            state_reg.exp      <= wpmt_pkg::FIRST_EXP;
            state_reg.pat      <= '0;
            state_reg.pend     <= 1'b0;
            state_reg.pend_exp <= '0;
            state_reg.err      <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/walking_pattern_memory_test.sv]
// ----------------------------------------------------------------------------
// walking_pattern_memory_test
// Memory self-test sequencer: walking ones/zeros data and address tests.
// ----------------------------------------------------------------------------
// Each input word (start, or a tick carrying the read data of the previous
// command) produces exactly one result word holding the next memory command,
// the compare result of the previous read, the phase, the error count and the
// done flag. An input word is registered, worked on combinationally by the
// sequencer step logic, and its result lands in the output register, from
// which it is offered. One word is
// taken every clock while the output side keeps up, set by the loop through
// the sequencer state register. The user must write the size register on the
// cfg channel only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module walking_pattern_memory_test #(
    parameter int DATA_WIDTH    = 64,
    parameter int LINE_WORDS    = 2,
    parameter int MAX_SIZE_LOG2 = 22
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // bits from 0: read_data
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // bits from 0: operation
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bits from 0: cmd_valid, cmd_write, cmd_word_address, cmd_data, mismatch,
    // test_phase, error_total, finished
    output logic [((DATA_WIDTH + 42 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [wpmt_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);

    localparam int OUT_W = ((DATA_WIDTH + 42 + 7) / 8) * 8;

    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [DATA_WIDTH-1:0]         in_data_reg;
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;
    logic [OUT_W-1:0]              out_data_next;
    logic [wpmt_pkg::CFG_W-1:0]    size_log2_reg;
    logic                          advance;

    logic                          cmd_valid;
    logic                          cmd_write;
    logic [wpmt_pkg::ADDR_W-1:0]   cmd_word_address;
    logic [DATA_WIDTH-1:0]         cmd_data;
    logic                          mismatch;
    logic [wpmt_pkg::PHASE_W-1:0]  test_phase;
    logic [wpmt_pkg::ERR_W-1:0]    error_total;
    logic                          finished;

    // handshake: the input stage moves when the output register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= wpmt_pkg::SIZE_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_log2_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg   <= s_axis_tuser[0];
            in_data_reg <= s_axis_tdata[DATA_WIDTH-1:0];
        end
    end

    wpmt_seq #(
        .DATA_WIDTH    (DATA_WIDTH),
        .LINE_WORDS    (LINE_WORDS),
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .operation        (in_op_reg),
        .read_data        (in_data_reg),
        .size_log2        (size_log2_reg),
        .cmd_valid        (cmd_valid),
        .cmd_write        (cmd_write),
        .cmd_word_address (cmd_word_address),
        .cmd_data         (cmd_data),
        .mismatch         (mismatch),
        .test_phase       (test_phase),
        .error_total      (error_total),
        .finished         (finished)
    );

    // pack the result word
    assign out_data_next = OUT_W'({finished, error_total, test_phase, mismatch,
                                   cmd_data, cmd_word_address, cmd_write, cmd_valid});

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

[dv/walking_pattern_memory_test_tb.sv]
// ----------------------------------------------------------------------------
// walking_pattern_memory_test_tb
// Self-checking bench for the walking ones/zeros memory test sequencer.
// ----------------------------------------------------------------------------
// A queue of input words (start, or tick carrying read data) feeds a clocked
// driver. Read data is chosen from a planning copy of the sequencer, so most
// reads come back right, a few with a flipped bit, some as junk. Every accepted
// word is run through the bench's own sequencer model and the expected result
// word is checked field by field against the output stream. The run covers a
// full test pass with size changes in the middle of the address tests, plus
// restarts and random traffic, under varying stall patterns on both sides.
// ----------------------------------------------------------------------------
module walking_pattern_memory_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W         = 64;
    localparam int LINE_W         = 2;
    localparam int MAX_LOG2       = 22;
    localparam int IN_W           = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_W          = ((DATA_W + 42 + 7) / 8) * 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 50;

    localparam logic [wpmt_pkg::CFG_W-1:0] MAX_SIZE = wpmt_pkg::CFG_W'(MAX_LOG2);
    localparam logic [2:0] SUB_L   = 3'(LINE_W);
    localparam logic [2:0] SUB_END = 3'(2 * LINE_W + 1);
    localparam logic [6:0] BP_END  = 7'(DATA_W);
    localparam logic [1:0] TW_END  = 2'(LINE_W);

    // one input word: operation and returned read data
    typedef struct packed {
        logic        op;
        logic [63:0] rdata;
    } stim_word_t;

    // one result word, cmd_valid in the lowest bit
    typedef struct packed {
        logic                           finished;
        logic [wpmt_pkg::ERR_W-1:0]     error_total;
        logic [wpmt_pkg::PHASE_W-1:0]   test_phase;
        logic                           mismatch;
        logic [DATA_W-1:0]              cmd_data;
        logic [wpmt_pkg::ADDR_W-1:0]    cmd_word_address;
        logic                           cmd_write;
        logic                           cmd_valid;
    } cmd_result_t;

    localparam int RES_W = $bits(cmd_result_t);

    // sequencer state as the bench tracks it
    typedef struct packed {
        logic [wpmt_pkg::CFG_W-1:0]   size_log2;
        wpmt_pkg::phase_t             phase;
        logic [1:0]                   target_word;
        logic [6:0]                   bit_pos;
        logic [2:0]                   sub_step;
        logic [wpmt_pkg::EXP_W-1:0]   offset_exp;
        logic [DATA_W-1:0]            pattern;
        logic                         pending_read;
        logic [DATA_W-1:0]            pending_exp;
        logic [wpmt_pkg::ERR_W-1:0]   err_count;
    } seq_state_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [IN_W-1:0]                  s_axis_tdata = '0;
    logic [0:0]                       s_axis_tuser = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [OUT_W-1:0]                 m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [wpmt_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;

    stim_word_t   word_q[$];
    cmd_result_t  result_q[$];
    seq_state_t   model_st;
    seq_state_t   plan_st;
    cmd_result_t  pred_word;
    cmd_result_t  seen_word;
    cmd_result_t  want_word;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic stall_out = 1'b0;
    int  words_in = 0;
    int  words_out = 0;
    int  flips_sent = 0;
    int  fail_count = 0;
    int  quiet_cycles = 0;

    walking_pattern_memory_test #(
        .DATA_WIDTH    (DATA_W),
        .LINE_WORDS    (LINE_W),
        .MAX_SIZE_LOG2 (MAX_LOG2)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------

    function automatic logic [wpmt_pkg::CFG_W-1:0] clamp_size(
        input logic [wpmt_pkg::CFG_W-1:0] sz);
        return (sz > MAX_SIZE) ? MAX_SIZE : sz;
    endfunction

    // first data word of an address pass
    function automatic logic [DATA_W-1:0] addr_seed(input wpmt_pkg::phase_t p);
        return (p == wpmt_pkg::PH_ADDR_ONES) ? wpmt_pkg::START_PATTERN
                                             : ~wpmt_pkg::START_PATTERN;
    endfunction

    function automatic void enter_addr_phase(inout seq_state_t st,
                                             input wpmt_pkg::phase_t p);
        st.phase      = p;
        st.sub_step   = '0;
        st.offset_exp = wpmt_pkg::FIRST_EXP;
        st.pattern    = addr_seed(p);
    endfunction

    // close passes whose offset already reached the size: write -> read -> next
    function automatic void settle_passes(inout seq_state_t st);
        while ((st.phase == wpmt_pkg::PH_ADDR_ONES || st.phase == wpmt_pkg::PH_ADDR_ZEROS) &&
               st.offset_exp >= clamp_size(st.size_log2))
        begin
            if (!st.sub_step[1])
            begin
                st.sub_step   = 3'd2;
                st.offset_exp = wpmt_pkg::FIRST_EXP;
                st.pattern    = addr_seed(st.phase);
            end
            else if (st.phase == wpmt_pkg::PH_ADDR_ONES)
                enter_addr_phase(st, wpmt_pkg::PH_ADDR_ZEROS);
            else
                st.phase = wpmt_pkg::PH_DONE;
        end
    endfunction

    // one input word in, one result word out
    function automatic cmd_result_t step_sequencer(inout seq_state_t st, input logic op,
                                                   input logic [63:0] rdata);
        cmd_result_t        res;
        logic [DATA_W-1:0]  one_hot;
        logic [DATA_W-1:0]  fill;
        logic [DATA_W-1:0]  pat;
        logic [DATA_W-1:0]  data_word;
        logic [63:0]        offset;
        logic [63:0]        span;
        logic [63:0]        byte_off;
        logic [63:0]        word_addr;
        logic [2:0]         s;
        logic [2:0]         r;
        res       = '0;
        data_word = '0;
        word_addr = '0;
        if (op == wpmt_pkg::OP_START)
        begin
            st.err_count    = '0;
            st.pending_read = 1'b0;
            st.pending_exp  = '0;
            st.phase        = wpmt_pkg::PH_DATA_ONES;
            st.target_word  = '0;
            st.bit_pos      = '0;
            st.sub_step     = '0;
            st.offset_exp   = wpmt_pkg::FIRST_EXP;
            st.pattern      = '0;
        end
        else if (st.pending_read)
        begin
            if (rdata != st.pending_exp)
            begin
                res.mismatch = 1'b1;
                if (st.err_count != wpmt_pkg::ERR_MAX)
                    st.err_count = st.err_count + 1'b1;
            end
            st.pending_read = 1'b0;
        end

        settle_passes(st);
        res.test_phase = st.phase;
        if (st.phase != wpmt_pkg::PH_DONE)
        begin
            res.cmd_valid = 1'b1;
            if (st.phase == wpmt_pkg::PH_DATA_ONES || st.phase == wpmt_pkg::PH_DATA_ZEROS)
            begin
                // data test: fill the line, write the target, read all back
                one_hot = 64'd1 << st.bit_pos[5:0];
                fill    = (st.phase == wpmt_pkg::PH_DATA_ONES) ? '0 : '1;
                pat     = (st.phase == wpmt_pkg::PH_DATA_ONES) ? one_hot : ~one_hot;
                s       = st.sub_step;
                if (s < SUB_L)
                begin
                    res.cmd_write = 1'b1;
                    word_addr     = 64'(s);
                    data_word     = fill;
                end
                else if (s == SUB_L)
                begin
                    res.cmd_write = 1'b1;
                    word_addr     = 64'(st.target_word);
                    data_word     = pat;
                end
                else
                begin
                    r = s - SUB_L - 3'd1;
                    res.cmd_write = 1'b0;
                    if (r + 3'd1 < SUB_L)
                    begin
                        word_addr = 64'(r);
                        if (r >= {1'b0, st.target_word})
                            word_addr = word_addr + 64'd1;
                        data_word = fill;
                    end
                    else
                    begin
                        word_addr = 64'(st.target_word);
                        data_word = pat;
                    end
                end
                st.sub_step = s + 3'd1;
                if (st.sub_step >= SUB_END)
                begin
                    st.sub_step = '0;
                    st.bit_pos  = st.bit_pos + 7'd1;
                    if (st.bit_pos >= BP_END)
                    begin
                        st.bit_pos = '0;
                        if (st.phase == wpmt_pkg::PH_DATA_ONES)
                            st.phase = wpmt_pkg::PH_DATA_ZEROS;
                        else
                        begin
                            st.phase       = wpmt_pkg::PH_DATA_ONES;
                            st.target_word = st.target_word + 2'd1;
                            if (st.target_word >= TW_END)
                            begin
                                st.target_word = '0;
                                enter_addr_phase(st, wpmt_pkg::PH_ADDR_ONES);
                            end
                        end
                    end
                end
            end
            else
            begin
                // address test: word pair at a power-of-two offset
                offset   = 64'd1 << st.offset_exp;
                span     = 64'd1 << clamp_size(st.size_log2);
                byte_off = (st.phase == wpmt_pkg::PH_ADDR_ONES) ? offset :
                           (~offset & ((span - 64'd1) &
                                       ~((64'd1 << wpmt_pkg::LOW_BITS) - 64'd1)));
                res.cmd_write = ~st.sub_step[1];
                word_addr     = byte_off / 64'(DATA_W / 8) + 64'(st.sub_step[0]);
                data_word     = st.pattern;
                if (st.phase == wpmt_pkg::PH_ADDR_ONES)
                    st.pattern = st.pattern + wpmt_pkg::PATTERN_STEP;
                else
                    st.pattern = st.pattern - wpmt_pkg::PATTERN_STEP;
                if (st.sub_step[0])
                begin
                    st.sub_step[0] = 1'b0;
                    st.offset_exp  = st.offset_exp + 1'b1;
                end
                else
                    st.sub_step[0] = 1'b1;
            end
            res.cmd_word_address = word_addr[wpmt_pkg::ADDR_W-1:0];
            res.cmd_data         = data_word;
            if (!res.cmd_write)
            begin
                st.pending_read = 1'b1;
                st.pending_exp  = data_word;
            end
            settle_passes(st);
        end
        res.error_total = st.err_count;
        res.finished    = (st.phase == wpmt_pkg::PH_DONE) && !st.pending_read;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    // queue a word and advance the planning copy
    task automatic push_word(input logic op, input logic [63:0] d);
        word_q.push_back('{op: op, rdata: d});
        void'(step_sequencer(plan_st, op, d));
    endtask

    // tick with read data: mostly right, sometimes a flipped bit or junk
    task automatic push_tick();
        logic [63:0] d;
        if (!plan_st.pending_read || $urandom_range(99) < 3)
            d = random64();
        else if ($urandom_range(99) < 8)
        begin
            d = plan_st.pending_exp ^ (64'd1 << $urandom_range(63));
            flips_sent++;
        end
        else
            d = plan_st.pending_exp;
        push_word(wpmt_pkg::OP_TICK, d);
    endtask

    // random traffic with occasional restarts
    task automatic push_noise();
        if ($urandom_range(99) < 6)
            push_word(wpmt_pkg::OP_START, random64());
        else
            push_tick();
    endtask

    // wait until every queued word is taken and every result is back
    task automatic wait_drain();
        do
            @(posedge clk);
        while (word_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // size register write, only while nothing is in flight
    task automatic write_size(input logic [wpmt_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_st.size_log2 = v;
        plan_st.size_log2  = v;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < REPORT_CAP)
            $display("mismatch at result word %0d: %s got %0h expected %0h",
                     words_out, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred_word = step_sequencer(model_st, s_axis_tuser[0], s_axis_tdata);
                result_q.push_back(pred_word);
                void'(word_q.pop_front());
                words_in++;
            end
            // slot is free unless a word is being held off
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= word_q[0].op;
                    s_axis_tdata  <= word_q[0].rdata;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_word = m_axis_tdata[RES_W-1:0];
                if (result_q.size() == 0)
                    report_mismatch("unexpected word", seen_word.cmd_data, '0);
                else
                begin
                    want_word = result_q.pop_front();
                    if (seen_word.cmd_valid != want_word.cmd_valid)
                        report_mismatch("cmd_valid", 64'(seen_word.cmd_valid),
                                        64'(want_word.cmd_valid));
                    if (seen_word.cmd_write != want_word.cmd_write)
                        report_mismatch("cmd_write", 64'(seen_word.cmd_write),
                                        64'(want_word.cmd_write));
                    if (seen_word.cmd_word_address != want_word.cmd_word_address)
                        report_mismatch("cmd_word_address", 64'(seen_word.cmd_word_address),
                                        64'(want_word.cmd_word_address));
                    if (seen_word.cmd_data != want_word.cmd_data)
                        report_mismatch("cmd_data", seen_word.cmd_data, want_word.cmd_data);
                    if (seen_word.mismatch != want_word.mismatch)
                        report_mismatch("mismatch", 64'(seen_word.mismatch),
                                        64'(want_word.mismatch));
                    if (seen_word.test_phase != want_word.test_phase)
                        report_mismatch("test_phase", 64'(seen_word.test_phase),
                                        64'(want_word.test_phase));
                    if (seen_word.error_total != want_word.error_total)
                        report_mismatch("error_total", 64'(seen_word.error_total),
                                        64'(want_word.error_total));
                    if (seen_word.finished != want_word.finished)
                        report_mismatch("finished", 64'(seen_word.finished),
                                        64'(want_word.finished));
                end
                words_out++;
            end
            m_axis_tready <= !stall_out && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long output hold-off so the block backs up into its input
    initial
    begin
        wait (words_in >= 300);
        @(posedge clk);
        stall_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_out <= 1'b0;
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        plan_st            = '0;
        plan_st.size_log2  = wpmt_pkg::SIZE_LOG2_RESET;
        plan_st.phase      = wpmt_pkg::PH_DONE;
        plan_st.offset_exp = wpmt_pkg::FIRST_EXP;
        model_st           = plan_st;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 10;
        recv_idle_pct = 70;

        // idle ticks before any start, then a start with junk data
        push_word(wpmt_pkg::OP_TICK, '0);
        push_word(wpmt_pkg::OP_TICK, '1);
        push_word(wpmt_pkg::OP_START, '1);
        repeat (3) push_word(wpmt_pkg::OP_TICK, random64());
        // first read issued, then both reads of the line answered right
        push_word(wpmt_pkg::OP_TICK, plan_st.pending_exp);
        push_word(wpmt_pkg::OP_TICK, plan_st.pending_exp);
        push_word(wpmt_pkg::OP_TICK, ~plan_st.pending_exp);
        repeat (3) push_word(wpmt_pkg::OP_TICK, random64());
        // restart with a read outstanding drops it
        push_word(wpmt_pkg::OP_START, ~plan_st.pending_exp);
        repeat (4) push_word(wpmt_pkg::OP_TICK, plan_st.pending_exp);
        push_word(wpmt_pkg::OP_TICK, plan_st.pending_exp ^ 64'h8000_0000_0000_0000);
        push_word(wpmt_pkg::OP_TICK, plan_st.pending_exp ^ 64'h1);
        wait_drain();

        // full test pass, first part of the data test
        write_size(5'd5);
        push_word(wpmt_pkg::OP_START, random64());
        repeat (450) push_tick();
        wait_drain();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 70;
        recv_idle_pct = 10;
        write_size(wpmt_pkg::SIZE_LOG2_RESET);
        repeat (450) push_tick();
        wait_drain();

        // no idling from here; above-max size acts as the max
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(5'd31);
        while (!(plan_st.phase == wpmt_pkg::PH_ADDR_ONES && !plan_st.sub_step[1] &&
                 plan_st.offset_exp >= 5'd12))
            push_tick();
        wait_drain();

        // shrink mid write pass: pass is already past the size
        write_size(5'd9);
        while (!(plan_st.phase == wpmt_pkg::PH_ADDR_ZEROS && !plan_st.sub_step[1] &&
                 plan_st.offset_exp >= 5'd6))
            push_tick();
        wait_drain();

        // grow mid write pass of the address zeros test
        write_size(5'd13);
        while (!(plan_st.phase == wpmt_pkg::PH_ADDR_ZEROS && plan_st.sub_step[1] &&
                 plan_st.offset_exp >= 5'd8))
            push_tick();
        wait_drain();

        // tiny size ends the address test at once, then idle ticks
        write_size(5'd0);
        repeat (8) push_tick();
        wait_drain();

        // random traffic with restarts at random sizes
        write_size(wpmt_pkg::CFG_W'($urandom_range(5, 22)));
        repeat (200) push_noise();
        wait_drain();
        write_size(wpmt_pkg::CFG_W'($urandom_range(31)));
        repeat (200) push_noise();
        wait_drain();

        $display("run: %0d input words, %0d result words, %0d corrupted reads sent",
                 words_in, words_out, flips_sent);
        $display("covered data/address tests, size changes, restarts, %0d-cycle stall",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
